@@ rtl/ovle_pkg.sv @@
`timescale 1ns / 1ps

package ovle_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned IdxW      = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned ValueW    = 32;
  localparam int unsigned ReqTypeW  = 2;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned MatchIdxW = 4;
  localparam int unsigned EntCntW   = 5;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 16;

  // request kinds
  localparam logic [ReqTypeW-1:0] REQ_INSERT = 2'd0;
  localparam logic [ReqTypeW-1:0] REQ_REMOVE = 2'd1;
  localparam logic [ReqTypeW-1:0] REQ_SEARCH = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] STAT_DONE      = 2'd0;
  localparam logic [StatusW-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] STAT_FULL      = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_EXEC
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic do_match;
    logic do_exec;
  } ovle_cmd_t;

endpackage

@@ rtl/ovle_ctrl.sv @@
`timescale 1ns / 1ps

module ovle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ovle_pkg::ovle_cmd_t cmd_o
);

  ovle_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ovle_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    // result taken downstream frees the output register
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ovle_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ovle_pkg::ST_MATCH;
        end
      end
      ovle_pkg::ST_MATCH: begin
        cmd_o.do_match = 1'b1;
        state_d        = ovle_pkg::ST_EXEC;
      end
      ovle_pkg::ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.do_exec = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ovle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ovle_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/ovle_dpath.sv @@
`timescale 1ns / 1ps

module ovle_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ovle_pkg::ovle_cmd_t                cmd_i,
  input  logic [ovle_pkg::ReqTypeW-1:0]      req_type_i,
  input  logic signed [ovle_pkg::ValueW-1:0] value_i,
  output logic [ovle_pkg::StatusW-1:0]       status_o,
  output logic [ovle_pkg::MatchIdxW-1:0]     match_index_o,
  output logic [ovle_pkg::EntCntW-1:0]       entry_count_o
);

  localparam int unsigned D = ovle_pkg::Depth;

  logic [ovle_pkg::ReqTypeW-1:0] req_type_q;
  logic [ovle_pkg::ValueW-1:0]   value_q;
  logic [D-1:0]                  match_q, match_d;
  logic [ovle_pkg::ValueW-1:0]   entries_q [D];
  logic [ovle_pkg::ValueW-1:0]   entries_d [D];
  logic [ovle_pkg::CntW-1:0]     count_q, count_d;

  logic [ovle_pkg::StatusW-1:0]   status_q, status_d;
  logic [ovle_pkg::MatchIdxW-1:0] match_index_q, match_index_d;
  logic [ovle_pkg::EntCntW-1:0]   entry_count_q;

  logic [D-1:0]              first_hit;
  logic [D-1:0]              tail_mask;
  logic [ovle_pkg::IdxW-1:0] hit_idx;
  logic                      any_hit;
  logic                      full;

  // compare cells: one per entry position, masked beyond the count
  always_comb begin
    for (int i = 0; i < D; i++) begin
      match_d[i] = (ovle_pkg::CntW'(i) < count_q) && (entries_q[i] == value_q);
    end
  end

  // first match as one-hot, and mask of positions at or behind it
  assign first_hit = match_q & ~(match_q - D'(1));
  assign tail_mask = ~(first_hit - D'(1));
  assign any_hit   = |match_q;
  assign full      = (count_q == ovle_pkg::CntW'(D));

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < D; i++) begin
      if (first_hit[i]) begin
        hit_idx = hit_idx | ovle_pkg::IdxW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < D; i++) begin
      entries_d[i] = entries_q[i];
    end
    count_d       = count_q;
    status_d      = ovle_pkg::STAT_NOT_FOUND;
    match_index_d = '0;
    case (req_type_q)
      ovle_pkg::REQ_INSERT: begin
        if (full) begin
          status_d = ovle_pkg::STAT_FULL;
        end else begin
          entries_d[0] = value_q;
          for (int i = 1; i < D; i++) begin
            entries_d[i] = entries_q[i-1];
          end
          count_d  = count_q + ovle_pkg::CntW'(1);
          status_d = ovle_pkg::STAT_DONE;
        end
      end
      ovle_pkg::REQ_REMOVE: begin
        if (any_hit) begin
          // close the gap behind the removed entry
          for (int i = 0; i < D - 1; i++) begin
            if (tail_mask[i]) begin
              entries_d[i] = entries_q[i+1];
            end
          end
          count_d       = count_q - ovle_pkg::CntW'(1);
          status_d      = ovle_pkg::STAT_DONE;
          match_index_d = ovle_pkg::MatchIdxW'(hit_idx);
        end
      end
      ovle_pkg::REQ_SEARCH: begin
        if (any_hit) begin
          status_d      = ovle_pkg::STAT_DONE;
          match_index_d = ovle_pkg::MatchIdxW'(hit_idx);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.do_exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q <= req_type_i;
      value_q    <= value_i;
    end
    if (cmd_i.do_match) begin
      match_q <= match_d;
    end
    if (cmd_i.do_exec) begin
      for (int i = 0; i < D; i++) begin
        entries_q[i] <= entries_d[i];
      end
      status_q      <= status_d;
      match_index_q <= match_index_d;
      entry_count_q <= ovle_pkg::EntCntW'(count_d);
    end
  end

  assign status_o      = status_q;
  assign match_index_o = match_index_q;
  assign entry_count_o = entry_count_q;

endmodule

@@ rtl/ordered_value_list_engine_core.sv @@
// Ordered value list engine: bounded list of 32-bit values, front at position 0.
// Each request is loaded, then compared, then applied (load, compare, update), and a new
// request is taken only once the last one's update is done; the update waits while an older
// result sits unaccepted in the output register, stalling the input.
// Reset (rst_ni low, asynchronous): list empty, no result pending; entry storage is
// not cleared, since entries past the count are never read.
`timescale 1ns / 1ps

module ordered_value_list_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] value (signed)
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [3:0] match_index, [8:4] entry_count, rest zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  ovle_pkg::ovle_cmd_t cmd;

  logic [ovle_pkg::StatusW-1:0]   status;
  logic [ovle_pkg::MatchIdxW-1:0] match_index;
  logic [ovle_pkg::EntCntW-1:0]   entry_count;

  // Controller sequences each request: IDLE takes it, MATCH registers the
  // per-entry compare vector, EXEC shifts the list on insert or remove and loads the result.
  ovle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Datapath: entry cells, compare cells, first-match encoder, count and
  // the result register.
  ovle_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (s_axis_tuser),
    .value_i       (s_axis_tdata),
    .status_o      (status),
    .match_index_o (match_index),
    .entry_count_o (entry_count)
  );

  assign m_axis_tdata = {7'd0, entry_count, match_index};
  assign m_axis_tuser = status;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned HoldCycles = 250;

  // request kind with no defined operation
  localparam logic [ovle_pkg::ReqTypeW-1:0] ReqUnused = 2'd3;

  typedef struct {
    logic [ovle_pkg::ReqTypeW-1:0] kind;
    logic [ovle_pkg::ValueW-1:0]   value;
    int unsigned                   gap;   // idle cycles before the request is offered
  } list_req_t;

  typedef struct {
    logic [ovle_pkg::StatusW-1:0]   status;
    logic [ovle_pkg::MatchIdxW-1:0] idx;
    logic [ovle_pkg::EntCntW-1:0]   cnt;
  } list_resp_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [ovle_pkg::InDataW-1:0]  s_tdata = '0;
  logic [1:0]                    s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [ovle_pkg::OutDataW-1:0] m_tdata;
  logic [1:0]                    m_tuser;

  ordered_value_list_engine_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser)
  );

  list_req_t   req_q[$];
  list_resp_t  resp_q[$];
  int unsigned n_total;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        hold_rx = 1'b0;

  // shadow of the list
  logic [ovle_pkg::ValueW-1:0] list_vals [ovle_pkg::Depth];
  int unsigned                 list_len = 0;

  logic [ovle_pkg::ValueW-1:0] pool [8];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch at result %0d: %s want %0h got %0h", n_checked, what, want, got);
    err_cnt++;
  endtask

  // Update the shadow list for one request and return the response it must produce.
  function automatic list_resp_t apply_request(logic [ovle_pkg::ReqTypeW-1:0] kind,
                                               logic [ovle_pkg::ValueW-1:0] v);
    list_resp_t  r;
    int unsigned pos;
    r.status = ovle_pkg::STAT_NOT_FOUND;
    r.idx    = '0;
    pos      = list_len;
    if (kind == ovle_pkg::REQ_REMOVE || kind == ovle_pkg::REQ_SEARCH) begin
      for (int i = int'(list_len) - 1; i >= 0; i--)
        if (list_vals[i] == v) pos = unsigned'(i);
    end
    if (kind == ovle_pkg::REQ_INSERT) begin
      if (list_len >= ovle_pkg::Depth) begin
        r.status = ovle_pkg::STAT_FULL;
      end else begin
        for (int i = int'(list_len); i > 0; i--) list_vals[i] = list_vals[i-1];
        list_vals[0] = v;
        list_len++;
        r.status = ovle_pkg::STAT_DONE;
      end
    end else if (kind == ovle_pkg::REQ_REMOVE && pos < list_len) begin
      for (int unsigned i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
      list_len--;
      r.status = ovle_pkg::STAT_DONE;
      r.idx    = pos[ovle_pkg::MatchIdxW-1:0];
    end else if (kind == ovle_pkg::REQ_SEARCH && pos < list_len) begin
      r.status = ovle_pkg::STAT_DONE;
      r.idx    = pos[ovle_pkg::MatchIdxW-1:0];
    end
    r.cnt = list_len[ovle_pkg::EntCntW-1:0];
    return r;
  endfunction

  task automatic push_req(logic [ovle_pkg::ReqTypeW-1:0] kind,
                          logic [ovle_pkg::ValueW-1:0] v, int unsigned gap);
    list_req_t it;
    it.kind  = kind;
    it.value = v;
    it.gap   = gap;
    req_q.push_back(it);
  endtask

  // Request side: each request waits its own gap, then is held until taken.
  always @(posedge clk_i) begin
    if (rst_ni && (!s_tvalid || s_tready)) begin : tx_side
      int unsigned gap_left;
      if (s_tvalid) begin
        resp_q.push_back(apply_request(s_tuser, s_tdata));
        n_accepted++;
      end
      if (req_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (gap_left < req_q[0].gap) begin
        gap_left++;
        s_tvalid <= 1'b0;
      end else begin
        gap_left = 0;
        s_tvalid <= 1'b1;
        s_tdata  <= req_q[0].value;
        s_tuser  <= req_q[0].kind;
        void'(req_q.pop_front());
      end
    end
  end

  // Result side: compare each response, then draw the stall before the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin : rx_side
      int unsigned stall_left;
      list_resp_t  exp_r;
      if (m_tvalid && m_tready) begin
        if (resp_q.size() == 0) begin
          report_mismatch("result with nothing pending", '0, 32'({m_tuser, m_tdata}));
        end else begin
          exp_r = resp_q.pop_front();
          if (m_tuser != exp_r.status)
            report_mismatch("status", 32'(exp_r.status), 32'(m_tuser));
          if (m_tdata[3:0] != exp_r.idx)
            report_mismatch("match_index", 32'(exp_r.idx), 32'(m_tdata[3:0]));
          if (m_tdata[8:4] != exp_r.cnt)
            report_mismatch("entry_count", 32'(exp_r.cnt), 32'(m_tdata[8:4]));
          if (m_tdata[15:9] != '0)
            report_mismatch("tdata padding", '0, 32'(m_tdata[15:9]));
        end
        n_checked++;
        // every third stretch of 150 results runs without stalls
        stall_left = ((n_checked / 150) % 3 == 2) ? 0 : $urandom_range(0, 6);
      end
      if (hold_rx) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Long back-pressure window so the request side backs up.
  initial begin
    wait (n_accepted >= 400);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned roll;
    int unsigned gap;
    logic [ovle_pkg::ReqTypeW-1:0] kind;
    logic [ovle_pkg::ValueW-1:0]   v;

    // directed: empty list, unused kind, extremes, first match, full list
    push_req(ovle_pkg::REQ_SEARCH, 32'h0000_0000, 0);
    push_req(ovle_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 0);
    push_req(ReqUnused, 32'h1234_5678, 1);
    push_req(ovle_pkg::REQ_INSERT, 32'h8000_0000, 0);
    push_req(ovle_pkg::REQ_INSERT, 32'h7FFF_FFFF, 0);
    push_req(ovle_pkg::REQ_SEARCH, 32'h8000_0000, 2);
    push_req(ovle_pkg::REQ_REMOVE, 32'h8000_0000, 0);
    for (int i = 0; i < 15; i++)
      push_req(ovle_pkg::REQ_INSERT,
               (i % 4 == 0) ? 32'h0000_0005 : 32'hA5A5_0000 + 32'(i), 0);
    push_req(ovle_pkg::REQ_INSERT, 32'hFFFF_FFFF, 0);      // full
    push_req(ovle_pkg::REQ_SEARCH, 32'h7FFF_FFFF, 0);      // last position
    push_req(ovle_pkg::REQ_REMOVE, 32'h0000_0005, 0);      // first of duplicates
    push_req(ovle_pkg::REQ_REMOVE, 32'h7FFF_FFFF, 3);

    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) pool[i] = $urandom;

    // random: even phases fill the list, odd phases drain it
    for (int p = 0; p < 11; p++) begin
      for (int n = 0; n < 100; n++) begin
        roll = $urandom_range(0, 99);
        if (roll >= 97)
          kind = ReqUnused;
        else if (roll < ((p % 2 == 0) ? 60 : 25))
          kind = ovle_pkg::REQ_INSERT;
        else if (roll < ((p % 2 == 0) ? 80 : 70))
          kind = ovle_pkg::REQ_REMOVE;
        else
          kind = ovle_pkg::REQ_SEARCH;
        v   = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)] : $urandom;
        gap = (p % 4 == 3) ? 0 : $urandom_range(0, 6);
        push_req(kind, v, gap);
      end
    end
    n_total = req_q.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(n_accepted == n_total && resp_q.size() == 0)) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (resp_q.size() != 0) report_mismatch("results missing", 32'(resp_q.size()), '0);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ovle_pkg.sv
rtl/ovle_ctrl.sv
rtl/ovle_dpath.sv
rtl/ordered_value_list_engine_core.sv
dv/tb_top.sv
